### sv/ctf_pkg.sv
// Package for the complementary tilt filter: sequencer states, CORDIC angle table
// and fixed-point constants. No dependencies.
`default_nettype none
package ctf_pkg;

  localparam int AtanLen = 24;
  localparam logic signed [23:0] Fine90  = 24'sd2949120;
  localparam logic signed [23:0] Fine180 = 24'sd5898240;

  // rounding divide by 1e9 / 2^9 through a reciprocal: floor(2^50 / DivD)
  localparam logic [20:0] DivD      = 21'd1953125;
  localparam logic [29:0] RecipM    = 30'd576460752;
  localparam logic [19:0] RoundHalf = 20'd976562;

  // register byte addresses
  localparam logic [3:0] CfgAddrWeight = 4'h0;
  localparam logic [3:0] CfgAddrPeriod = 4'h4;
  localparam logic [3:0] CfgAddrTick   = 4'h8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQRT,
    ST_CORD,
    ST_PROD,
    ST_PROP,
    ST_BLEND,
    ST_NEXT,
    ST_DONE
  } ctf_state_t;

  // atan(2^-i) in 1/32768 deg
  function automatic logic [23:0] atan_fine(input logic [4:0] i);
    logic [23:0] r;
    case (i)
      5'd0:  r = 24'd1474560;
      5'd1:  r = 24'd870484;
      5'd2:  r = 24'd459940;
      5'd3:  r = 24'd233473;
      5'd4:  r = 24'd117189;
      5'd5:  r = 24'd58652;
      5'd6:  r = 24'd29333;
      5'd7:  r = 24'd14667;
      5'd8:  r = 24'd7334;
      5'd9:  r = 24'd3667;
      5'd10: r = 24'd1833;
      5'd11: r = 24'd917;
      5'd12: r = 24'd458;
      5'd13: r = 24'd229;
      5'd14: r = 24'd115;
      5'd15: r = 24'd57;
      5'd16: r = 24'd29;
      5'd17: r = 24'd14;
      5'd18: r = 24'd7;
      5'd19: r = 24'd4;
      5'd20: r = 24'd2;
      5'd21: r = 24'd1;
      default: r = 24'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### sv/ctf_datapath.sv
// Shared iterative datapath: square root, CORDIC vectoring, gyro propagation and blend.
// Depends on ctf_pkg; sequenced by ctf_seq.
`default_nettype none
module ctf_datapath
  import ctf_pkg::*;
(
  input  wire               clk,
  input  ctf_state_t        state,
  input  wire               start,
  input  wire               axis_sel,
  input  wire [4:0]         step,
  input  wire signed [15:0] accel_x,
  input  wire signed [15:0] accel_y,
  input  wire signed [15:0] accel_z,
  input  wire signed [15:0] rate,
  input  wire signed [15:0] est,
  input  wire [15:0]        interval,
  input  wire [15:0]        tick_ns,
  input  wire [16:0]        weight,
  input  wire               invalid,
  output logic signed [15:0] new_est
);

  // operands of the current axis
  logic signed [15:0] a, b;
  assign a = axis_sel ? accel_y : accel_x;
  assign b = axis_sel ? accel_x : accel_y;

  // sqrt radicand and root: (b^2 + c^2) * 2^16 fits 48 bits
  logic [47:0] rem_r, rem_nxt;
  logic [24:0] root_r, root_nxt;
  logic [31:0] sqb_r, sqb_nxt;
  logic signed [27:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [24:0] cz_r, cz_nxt;
  logic signed [47:0] prod_r, prod_nxt;
  logic signed [41:0] prop_r, prop_nxt;
  logic signed [59:0] sum_r, sum_nxt;
  logic [55:0] dv_r, dv_nxt;
  logic [21:0] dr_r, dr_nxt;

  logic [16:0] wq;
  assign wq = (weight > 17'd65536) ? 17'd65536 : weight;

  logic [49:0] trial;
  logic [5:0]  sh2;
  logic signed [27:0] dx, dy;
  logic signed [24:0] zc;
  logic signed [23:0] acc;
  logic [15:0] absa;
  logic [47:0] pabs;
  logic [49:0] num;
  logic [29:0] qa;
  logic signed [41:0] qf;
  logic [29:0] mul_a, mul_b;
  logic [59:0] mul_p;
  logic signed [59:0] rnd, shq;

  // rounding divide of |rate * interval * tick| * 2048 by 1e9
  assign pabs = prod_r[47] ? 48'(-prod_r) : 48'(prod_r);
  assign num  = {pabs, 2'b00} + 50'(RoundHalf);
  assign qa   = dv_r[54:25];
  assign qf   = 42'(42'(qa) + 42'(dr_r >= 22'(DivD)));

  // shared 30x30 multiplier for the reciprocal divide
  always_comb begin
    mul_a = '0;
    mul_b = RecipM;
    if (state == ST_PROP) begin
      case (step)
        5'd0: mul_a = 30'(num[24:0]);
        5'd1: mul_a = 30'(num[49:25]);
        default: begin
          mul_a = qa;
          mul_b = 30'(DivD);
        end
      endcase
    end
  end

  assign mul_p = 60'(mul_a) * 60'(mul_b);

  always_comb begin
    rem_nxt  = rem_r;
    root_nxt = root_r;
    sqb_nxt  = sqb_r;
    cx_nxt   = cx_r;
    cy_nxt   = cy_r;
    cz_nxt   = cz_r;
    prod_nxt = prod_r;
    prop_nxt = prop_r;
    sum_nxt  = sum_r;
    dv_nxt   = dv_r;
    dr_nxt   = dr_r;
    sh2      = 6'(6'd46 - {step, 1'b0});
    trial    = {2'b00, rem_r >> sh2} - {23'd0, root_r, 2'b01};
    dx       = cy_r >>> step;
    dy       = cx_r >>> step;
    absa     = a[15] ? 16'(-a) : a;
    zc       = (cz_r < 0) ? 25'sd0 : ((cz_r > 25'(Fine90)) ? 25'(Fine90) : cz_r);
    acc      = a[15] ? 24'(25'(Fine180) - zc) : zc[23:0];
    rnd      = sum_r + 60'sd8388608;
    case (state)
      ST_SQX: begin
        // square of b, then add c^2
        if (start) sqb_nxt = 32'(b) * 32'(b);
        else sqb_nxt = 32'(sqb_r + 32'(accel_z) * 32'(accel_z));
        rem_nxt  = {sqb_nxt, 16'd0};
        root_nxt = '0;
      end
      ST_SQRT: begin
        // one result bit per cycle, restoring method on 48-bit radicand
        if (!trial[49]) begin
          rem_nxt  = 48'(rem_r - (({23'd0, root_r, 2'b01}) << sh2));
          root_nxt = {root_r[23:0], 1'b1};
        end else begin
          root_nxt = {root_r[23:0], 1'b0};
        end
        cx_nxt = 28'($signed({1'b0, absa, 8'd0}));
        cy_nxt = 28'($signed({1'b0, root_nxt}));
        cz_nxt = '0;
      end
      ST_CORD: begin
        if (cy_r >= 0) begin
          cx_nxt = cx_r + dx; cy_nxt = cy_r - dy;
          cz_nxt = cz_r + 25'($signed({1'b0, atan_fine(step)}));
        end else begin
          cx_nxt = cx_r - dx; cy_nxt = cy_r + dy;
          cz_nxt = cz_r - 25'($signed({1'b0, atan_fine(step)}));
        end
      end
      ST_PROD: begin
        if (start) prod_nxt = 48'(rate) * 48'($signed({1'b0, interval}));
        else prod_nxt = prod_r * 48'($signed({1'b0, tick_ns}));
      end
      ST_PROP: begin
        // low and high partial products, remainder check, then propagation
        case (step)
          5'd0: dv_nxt = 56'(mul_p);
          5'd1: dv_nxt = 56'(mul_p) + 56'(dv_r >> 25);
          5'd2: dr_nxt = 22'(num - 50'(mul_p));
          default: begin
            prop_nxt = 42'($signed(est) * 42'sd256) + ((prod_r < 0) ? -qf : qf);
          end
        endcase
      end
      ST_BLEND: begin
        if (invalid) sum_nxt = 60'(prop_r) <<< 16;
        else sum_nxt = 60'(prop_r) * 60'($signed({1'b0, wq})) +
                       60'($signed({1'b0, 17'(17'd65536 - wq)})) * 60'(acc);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    sqb_r  <= sqb_nxt;
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    cz_r   <= cz_nxt;
    prod_r <= prod_nxt;
    prop_r <= prop_nxt;
    sum_r  <= sum_nxt;
    dv_r   <= dv_nxt;
    dr_r   <= dr_nxt;
  end

  // rounded and saturated estimate, valid while the sequencer is in ST_NEXT
  always_comb begin
    shq = rnd >>> 24;
    if (shq > 60'sd32767) new_est = 16'sh7fff;
    else if (shq < -60'sd32768) new_est = 16'sh8000;
    else new_est = 16'(shq);
  end

endmodule
`default_nettype wire

### sv/ctf_seq.sv
// Sequencer: walks each axis through sqrt, CORDIC, propagation and blend steps;
// an axis with invalid set skips sqrt and CORDIC. Depends on ctf_pkg.
`default_nettype none
module ctf_seq
  import ctf_pkg::*;
#(
  parameter int CordicIterations = 16
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        go,
  input  wire        invalid,
  input  wire        out_taken,
  output ctf_state_t state,
  output logic       start,
  output logic       axis_sel,
  output logic [4:0] step,
  output logic       axis_done
);

  localparam logic [4:0] LastCord = 5'(((CordicIterations < AtanLen) ?
                                        CordicIterations : AtanLen) - 1);

  ctf_state_t st_r, st_nxt;
  logic [4:0] step_r, step_nxt;
  logic axis_r, axis_nxt;

  // next state
  always_comb begin
    st_nxt   = st_r;
    step_nxt = step_r + 5'd1;
    axis_nxt = axis_r;
    case (st_r)
      ST_IDLE: begin
        step_nxt = '0; axis_nxt = 1'b0;
        if (go) st_nxt = invalid ? ST_PROD : ST_SQX;
      end
      ST_SQX:  if (step_r == 5'd1) begin st_nxt = ST_SQRT; step_nxt = '0; end
      ST_SQRT: if (step_r == 5'd23) begin st_nxt = ST_CORD; step_nxt = '0; end
      ST_CORD: if (step_r == LastCord) begin st_nxt = ST_PROD; step_nxt = '0; end
      ST_PROD: if (step_r == 5'd1) begin st_nxt = ST_PROP; step_nxt = '0; end
      ST_PROP: if (step_r == 5'd3) begin st_nxt = ST_BLEND; step_nxt = '0; end
      ST_BLEND: st_nxt = ST_NEXT;
      ST_NEXT: begin
        step_nxt = '0;
        if (axis_r) st_nxt = ST_DONE;
        else begin
          axis_nxt = 1'b1;
          st_nxt = invalid ? ST_PROD : ST_SQX;
        end
      end
      ST_DONE: if (out_taken) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; step_r <= '0; axis_r <= 1'b0;
    end else begin
      st_r <= st_nxt; step_r <= step_nxt; axis_r <= axis_nxt;
    end
  end

  // outputs
  always_comb begin
    state     = st_r;
    step      = step_r;
    axis_sel  = axis_r;
    start     = (step_r == 5'd0);
    axis_done = (st_r == ST_NEXT);
  end

endmodule
`default_nettype wire

### sv/complementary_tilt_filter_core.sv
// Complementary tilt filter top: APB registers, stream ports, filter state.
// Depends on ctf_pkg, ctf_seq, ctf_datapath.
// A new input is taken only after the result of the previous one has been transferred.
// A zero accelerometer vector skips sqrt and CORDIC for both axes.
// Synchronous active-low reset restores register defaults and clears the estimates.
`default_nettype none
module complementary_tilt_filter_core
  import ctf_pkg::*;
#(
  parameter int CordicIterations = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  // accel_x[15:0], accel_y[31:16], accel_z[47:32], rate_x[63:48], rate_y[79:64],
  // timer_count[95:80]
  input  wire [95:0]  in_tdata,
  output logic        out_tvalid,
  input  wire         out_tready,
  // x_estimate[15:0], y_estimate[31:16], interval_ticks[47:32]
  output logic [47:0] out_tdata,
  // accel_invalid
  output logic        out_tuser,
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire [3:0]   cfg_paddr,
  input  wire [31:0]  cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [16:0] weight_r;
  logic [15:0] period_r, tick_r;
  logic [95:0] item_r;
  logic inv_r;
  logic signed [15:0] xest_r, yest_r;
  logic [15:0] prev_r, intv_r;

  ctf_state_t state;
  logic start, axis_sel, axis_done;
  logic [4:0] step;
  logic signed [15:0] new_est;
  logic go, taken;
  logic [15:0] cnt;

  assign in_tready  = (state == ST_IDLE);
  assign go         = in_tvalid && in_tready;
  assign out_tvalid = (state == ST_DONE);
  assign taken      = out_tvalid && out_tready;
  assign cfg_pready = 1'b1;
  assign cnt        = item_r[95:80];

  ctf_seq #(.CordicIterations(CordicIterations)) u_seq (
    .clk, .rst_n, .go,
    .invalid(state == ST_IDLE ? (in_tdata[47:0] == 48'd0) : inv_r),
    .out_taken(taken), .state, .start, .axis_sel, .step, .axis_done
  );

  ctf_datapath u_dp (
    .clk, .state, .start, .axis_sel, .step,
    .accel_x(item_r[15:0]), .accel_y(item_r[31:16]), .accel_z(item_r[47:32]),
    .rate(axis_sel ? item_r[79:64] : item_r[63:48]),
    .est(axis_sel ? yest_r : xest_r),
    .interval(intv_r), .tick_ns(tick_r), .weight(weight_r), .invalid(inv_r),
    .new_est
  );

  // registers, input capture and state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= 17'd64225; period_r <= 16'd50000; tick_r <= 16'd500;
      xest_r <= '0; yest_r <= '0; prev_r <= '0; intv_r <= '0; inv_r <= 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        case (cfg_paddr)
          CfgAddrWeight: weight_r <= cfg_pwdata[16:0];
          CfgAddrPeriod: period_r <= cfg_pwdata[15:0];
          CfgAddrTick:   tick_r   <= cfg_pwdata[15:0];
          default: ;
        endcase
      end
      if (go) inv_r <= (in_tdata[47:0] == 48'd0);
      if (state == ST_NEXT && axis_done) begin
        if (axis_sel) begin
          yest_r <= new_est;
          if (cnt > prev_r) intv_r <= cnt - prev_r;
          else if (cnt < prev_r) intv_r <= 16'(period_r - prev_r + cnt);
          prev_r <= cnt;
        end else xest_r <= new_est;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) item_r <= in_tdata;
  end

  // read-back
  always_comb begin
    case (cfg_paddr)
      CfgAddrWeight: cfg_prdata = {15'd0, weight_r};
      CfgAddrPeriod: cfg_prdata = {16'd0, period_r};
      CfgAddrTick:   cfg_prdata = {16'd0, tick_r};
      default: cfg_prdata = '0;
    endcase
  end

  assign out_tdata = {intv_r, yest_r, xest_r};
  assign out_tuser = inv_r;

endmodule
`default_nettype wire
